// ===== hw/rtl/tcfc_pkg.sv =====
// Shared constants and types for the text column field cutter.
package tcfc_pkg;

    // Default sizes of the top-level parameters
    localparam int HOLD_DEPTH_DEF  = 32;
    localparam int RANGE_SLOTS_DEF = 4;
    localparam int COLUMN_BITS_DEF = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_A     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_PAIR  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_COUNT = 3'd7;

    // Bit positions in the mode register
    localparam int MODE_CHAR       = 0;
    localparam int MODE_FIELD      = 1;
    localparam int MODE_NO_SQUEEZE = 2;
    localparam int MODE_KEEP_EMPTY = 3;
    localparam int MODE_LAST_COL   = 4;

    // Reset values
    localparam logic [31:0] RANGE_RESET       = 32'hFFFF_FFFF;
    localparam logic [2:0]  ACTIVE_RESET      = 3'd0;
    localparam logic [4:0]  MODE_RESET        = 5'd0;
    localparam logic [15:0] DELIM_PAIR_RESET  = 16'h0920;
    localparam logic [1:0]  DELIM_COUNT_RESET = 2'd2;

    localparam logic [15:0] RANGE_END    = 16'hFFFF;
    localparam logic [7:0]  NEWLINE_BYTE = 8'h0A;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SEND = 3'b010,
        S_NEWL = 3'b100
    } t_state;

endpackage

// ===== hw/rtl/tcfc_hold_ram.sv =====
// Hold store: one write port, one read port with registered read data.
module tcfc_hold_ram import tcfc_pkg::*; #(
    parameter int DEPTH = HOLD_DEPTH_DEF,
    parameter int AW    = $clog2(HOLD_DEPTH_DEF)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tcfc_range_match.sv =====
// Range selector: decides whether a column falls in one of the active ranges.
module tcfc_range_match import tcfc_pkg::*; #(
    parameter int RANGE_SLOTS = RANGE_SLOTS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
    input  logic [RANGE_SLOTS-1:0][31:0] i_ranges,
    input  logic [2:0]                   i_active,
    input  logic [COLUMN_BITS-1:0]       i_column,
    output logic                         o_selected
);

    always_comb begin
        logic [2:0]  n_slots;
        logic [31:0] col;
        logic [31:0] start;
        logic [31:0] stop;
        logic        done;
        logic        sel;
        n_slots = (i_active > 3'(RANGE_SLOTS)) ? 3'(RANGE_SLOTS) : i_active;
        col     = 32'(i_column);
        done    = 1'b0;
        sel     = 1'b0;
        for (int i = 0; i < RANGE_SLOTS; i++) begin
            start = (i_ranges[i][31:16] == RANGE_END) ? 32'hFFFF_FFFF
                                                      : 32'(i_ranges[i][31:16]);
            stop  = (i_ranges[i][15:0] == RANGE_END) ? 32'hFFFF_FFFF
                                                     : 32'(i_ranges[i][15:0]);
            if (!done && (3'(i) < n_slots)) begin
                // stop searching at the first range that starts above the column
                if (col < start) begin
                    done = 1'b1;
                end else if ((col == start) || (col <= stop)) begin
                    sel  = 1'b1;
                    done = 1'b1;
                end
            end
        end
        o_selected = sel;
    end

endmodule

// ===== hw/rtl/text_column_field_cutter.sv =====
// Text column field cutter: top level with line state, control and output register.
// The result of a byte sits in the output register in the cycle after its transfer.
// Throughput: one byte per cycle while idle and the output is free; a newline that flushes
// held bytes stalls input until sent, paced by the single read port of the hold RAM.
// Reset: i_rst_n, synchronous, active low, clears line state, control and configuration;
// the hold RAM keeps its contents and needs no clearing pass.
module text_column_field_cutter import tcfc_pkg::*; #(
    parameter int HOLD_DEPTH  = HOLD_DEPTH_DEF,
    parameter int RANGE_SLOTS = RANGE_SLOTS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input byte channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_file_start,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_out_byte,
    output logic                  o_last_of_run,
    output logic                  o_hold_truncated
);

    // address bits of the hold RAM and bits of the fill count (which must reach the depth)
    localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CW = $clog2(HOLD_DEPTH + 1);

    // ---------------- configuration registers ----------------
    logic [RANGE_SLOTS-1:0][31:0] r_ranges;
    logic [2:0]                   r_active;
    logic [4:0]                   r_mode;
    logic [15:0]                  r_delim_pair;
    logic [1:0]                   r_delim_count;

    // Slots above RANGE_SLOTS are not stored; a write to them is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RANGE_SLOTS; i++) begin
                r_ranges[i] <= RANGE_RESET;
            end
            r_active      <= ACTIVE_RESET;
            r_mode        <= MODE_RESET;
            r_delim_pair  <= DELIM_PAIR_RESET;
            r_delim_count <= DELIM_COUNT_RESET;
        end else if (i_cfg_we) begin
            for (int i = 0; i < RANGE_SLOTS; i++) begin
                if (i_cfg_index == REG_RANGE_A + CFG_IDX_W'(i)) begin
                    r_ranges[i] <= i_cfg_data[31:0];
                end
            end
            if (i_cfg_index == REG_ACTIVE) begin
                r_active <= i_cfg_data[2:0];
            end
            if (i_cfg_index == REG_MODE) begin
                r_mode <= i_cfg_data[4:0];
            end
            if (i_cfg_index == REG_DELIM_PAIR) begin
                r_delim_pair <= i_cfg_data[15:0];
            end
            if (i_cfg_index == REG_DELIM_COUNT) begin
                r_delim_count <= i_cfg_data[1:0];
            end
        end
    end

    logic char_mode, field_mode, no_squeeze, keep_empty, flush_last;
    assign char_mode  = r_mode[MODE_CHAR];
    assign field_mode = r_mode[MODE_FIELD];
    assign no_squeeze = r_mode[MODE_NO_SQUEEZE];
    assign keep_empty = r_mode[MODE_KEEP_EMPTY];
    assign flush_last = r_mode[MODE_LAST_COL];

    // ---------------- line state and control ----------------
    t_state                 r_state, n_state;
    logic [COLUMN_BITS-1:0] r_col, n_col;
    logic                   r_run, n_run;
    logic                   r_empty, n_empty;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_ovf, n_ovf;

    // flush sequencer: current read address, last address, trailing newline, flag snapshot
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_end, n_end;
    logic          r_fl_nl, n_fl_nl;
    logic          r_fl_trunc, n_fl_trunc;

    // output register
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_last, n_out_last;
    logic       r_out_trunc, n_out_trunc;

    // hold RAM ports
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    logic out_free, in_take;

    // The output register can take a new result when empty or being drained now.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_take    = i_in_valid && !o_in_stall;

    // ---------------- stage one: file start and delimiter handling ----------------
    // Line state as seen after an optional file start clear.
    logic [COLUMN_BITS-1:0] e_col;
    logic                   e_run, e_empty, e_ovf;
    logic [CW-1:0]          e_cnt;

    assign e_col   = i_file_start ? '0   : r_col;
    assign e_run   = i_file_start ? 1'b0 : r_run;
    assign e_empty = i_file_start ? 1'b1 : r_empty;
    assign e_cnt   = i_file_start ? '0   : r_cnt;
    assign e_ovf   = i_file_start ? 1'b0 : r_ovf;

    logic                   is_nl, is_delim;
    logic [COLUMN_BITS-1:0] a_col;
    logic                   a_run, a_ovf, a_go;
    logic [CW-1:0]          a_cnt;
    logic [7:0]             a_byte;

    assign is_nl    = (i_in_byte == NEWLINE_BYTE);
    assign is_delim = (r_delim_count != 2'd0)
                   && ((i_in_byte == r_delim_pair[7:0])
                    || ((r_delim_count >= 2'd2) && (i_in_byte == r_delim_pair[15:8])));

    always_comb begin
        a_col  = e_col;
        a_run  = e_run;
        a_cnt  = e_cnt;
        a_ovf  = e_ovf;
        a_byte = i_in_byte;
        a_go   = !is_nl;
        if (!is_nl && field_mode) begin
            if (is_delim) begin
                if (e_run && !no_squeeze) begin
                    // squeezed delimiter: drop it and leave the line state alone
                    a_go = 1'b0;
                end else begin
                    if (e_col != '1) begin
                        a_col = e_col + 1'b1;
                    end
                    // when squeezing, the first delimiter of a run becomes the low delimiter byte
                    if (!e_run && !no_squeeze) begin
                        a_byte = r_delim_pair[7:0];
                    end
                    a_run = 1'b1;
                    a_cnt = '0;
                    a_ovf = 1'b0;
                    // nothing selected yet on this line: drop the delimiter
                    if (e_empty) begin
                        a_go = 1'b0;
                    end
                end
            end else begin
                a_run = 1'b0;
            end
        end
    end

    logic selected;

    tcfc_range_match #(
        .RANGE_SLOTS (RANGE_SLOTS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_match (
        .i_ranges   (r_ranges),
        .i_active   (r_active),
        .i_column   (a_col),
        .o_selected (selected)
    );

    // ---------------- stage two: select, hold, flush ----------------
    always_comb begin
        logic [CW-1:0] cnt_m1;
        cnt_m1 = e_cnt - 1'b1;

        n_state     = r_state;
        n_col       = r_col;
        n_run       = r_run;
        n_empty     = r_empty;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_addr      = r_addr;
        n_end       = r_end;
        n_fl_nl     = r_fl_nl;
        n_fl_trunc  = r_fl_trunc;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_trunc = r_out_trunc;
        ram_we      = 1'b0;
        ram_waddr   = a_cnt[AW-1:0];
        ram_wdata   = a_byte;
        ram_re      = 1'b0;
        ram_raddr   = r_addr;

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    if (is_nl) begin
                        if (flush_last && (e_cnt != '0)) begin
                            // start the flush: char mode sends the newest held byte only
                            n_state    = S_SEND;
                            ram_re     = 1'b1;
                            ram_raddr  = char_mode ? cnt_m1[AW-1:0] : '0;
                            n_addr     = ram_raddr;
                            n_end      = cnt_m1[AW-1:0];
                            n_fl_nl    = !e_empty || keep_empty;
                            n_fl_trunc = e_ovf;
                        end else if (!e_empty || keep_empty) begin
                            n_out_valid = 1'b1;
                            n_out_byte  = NEWLINE_BYTE;
                            n_out_last  = 1'b1;
                            n_out_trunc = e_ovf;
                        end
                        n_col   = '0;
                        n_run   = 1'b0;
                        n_empty = 1'b1;
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                    end else begin
                        n_col   = a_col;
                        n_run   = a_run;
                        n_empty = e_empty;
                        n_cnt   = a_cnt;
                        n_ovf   = a_ovf;
                        if (a_go) begin
                            if (selected) begin
                                n_out_valid = 1'b1;
                                n_out_byte  = a_byte;
                                n_out_last  = 1'b1;
                                n_out_trunc = a_ovf;
                                n_empty     = 1'b0;
                                n_cnt       = '0;
                                n_ovf       = 1'b0;
                            end else if (a_cnt < CW'(HOLD_DEPTH)) begin
                                ram_we = 1'b1;
                                n_cnt  = a_cnt + 1'b1;
                            end else begin
                                // store full: drop the byte and flag it
                                n_ovf = 1'b1;
                            end
                            if (char_mode && (a_col != '1)) begin
                                n_col = a_col + 1'b1;
                            end
                        end
                    end
                end
            end
            S_SEND: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = ram_rdata;
                    n_out_last  = (r_addr == r_end) && !r_fl_nl;
                    n_out_trunc = r_fl_trunc;
                    if (r_addr == r_end) begin
                        n_state = r_fl_nl ? S_NEWL : S_IDLE;
                    end else begin
                        // advance and fetch the next held byte
                        n_addr    = r_addr + 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = n_addr;
                    end
                end
            end
            S_NEWL: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = NEWLINE_BYTE;
                    n_out_last  = 1'b1;
                    n_out_trunc = r_fl_trunc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_run       <= 1'b0;
            r_empty     <= 1'b1;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_run       <= n_run;
            r_empty     <= n_empty;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and flush bookkeeping: no reset needed
    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_end       <= n_end;
        r_fl_nl     <= n_fl_nl;
        r_fl_trunc  <= n_fl_trunc;
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
        r_out_trunc <= n_out_trunc;
    end

    tcfc_hold_ram #(
        .DEPTH (HOLD_DEPTH),
        .AW    (AW)
    ) u_hold (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_last_of_run    = r_out_last;
    assign o_hold_truncated = r_out_trunc;

endmodule
